// ===== hw/rtl/vbrl_pkg.sv =====
// Package for the virtual button repress lockout block: request/response types and codes.
`timescale 1ns / 1ps

package vbrl_pkg;

	localparam int OP_W       = 3;
	localparam int BTN_W      = 4;
	localparam int FIELD_TW   = 32;
	localparam int OUT_MASK_W = 7;
	localparam int LOCK_W     = 16;
	localparam int STATUS_W   = 2;

	localparam logic [OP_W-1:0] OP_SET      = 3'd0;
	localparam logic [OP_W-1:0] OP_CLICK    = 3'd1;
	localparam logic [OP_W-1:0] OP_ACTIVITY = 3'd2;
	localparam logic [OP_W-1:0] OP_FRAME    = 3'd3;
	localparam logic [OP_W-1:0] OP_CLEAR    = 3'd4;

	localparam logic [STATUS_W-1:0] ST_APPLIED  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD      = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOCHANGE = 2'd2;
	localparam logic [STATUS_W-1:0] ST_LOCKOUT  = 2'd3;

	localparam logic [LOCK_W-1:0] LOCKOUT_RESET = 16'd250;

	typedef struct packed {
		logic [OP_W-1:0]     operation;
		logic [BTN_W-1:0]    button;
		logic                press;
		logic [FIELD_TW-1:0] now_ms;
		logic                usb_level;
	} vbrl_req_t;

	typedef struct packed {
		logic [OUT_MASK_W-1:0] current_mask;
		logic [OUT_MASK_W-1:0] pressed_edges;
		logic [OUT_MASK_W-1:0] released_edges;
		logic [FIELD_TW-1:0]   held_ms;
		logic [FIELD_TW-1:0]   max_held_ms;
		logic                  usb_changed;
		logic [STATUS_W-1:0]   status;
	} vbrl_rsp_t;

endpackage

// ===== hw/rtl/virtual_button_repress_lockout.sv =====
// Virtual button qualifier with repress lockout, frame latching and held-time report.
// Each request is registered in stage 1, then in stage 2, then in the response register.
// Throughput: one request per cycle unless rsp_ready stalls the output; state is updated
// in stage 1; held times and their maximum are formed from the updated state in stage 2.
// Reset: asynchronous, clears masks, timestamps and USB state; lockout returns to 250 ms.
`timescale 1ns / 1ps

module virtual_button_repress_lockout
	import vbrl_pkg::*;
#(
	parameter int NUM_BUTTONS = 7,
	parameter int TIME_BITS   = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  vbrl_req_t         req,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output vbrl_rsp_t         rsp,
	input  logic              cfg_we,
	input  logic [LOCK_W-1:0] cfg_wdata
);

	localparam int NB = NUM_BUTTONS;
	localparam int TW = TIME_BITS;
	localparam int IW = (NB > 1) ? $clog2(NB) : 1;

	logic [LOCK_W-1:0] lockout_q;
	logic [NB-1:0]     desired_q;
	logic [NB-1:0]     latched_q;
	logic [NB-1:0]     prior_q;
	logic [TW-1:0]     start_q [NB];
	logic [TW-1:0]     finish_q [NB];
	logic [TW-1:0]     act_q [NB];
	logic              last_usb_q;
	logic              usb_flag_q;

	logic              v_s1;
	logic [OP_W-1:0]   op_s1;
	logic [BTN_W-1:0]  btn_s1;
	logic              press_s1;
	logic [TW-1:0]     now_s1;
	logic              usb_s1;

	logic              v_s2;
	logic              bval_s2;
	logic [IW-1:0]     idx_s2;
	logic [TW-1:0]     now_s2;
	logic [STATUS_W-1:0] status_s2;

	logic              rsp_valid_q;
	vbrl_rsp_t         rsp_q;

	logic              out_free;
	logic              s2_move;
	logic              s1_move;

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign s2_move   = !v_s2 || out_free;
	assign s1_move   = !v_s1 || s2_move;
	assign req_ready = s1_move;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// Stage 1: decide the state update for the request.
	logic                bval_s1;
	logic [IW-1:0]       idx_s1;
	logic                d_cur;
	logic [TW-1:0]       st_cur;
	logic [TW-1:0]       fin_cur;
	logic [TW-1:0]       act_cur;
	logic                lock;
	logic [TW-1:0]       rel_fin;
	logic [STATUS_W-1:0] status_s1;
	logic                d_new;
	logic                w_start;
	logic                w_fin;
	logic [TW-1:0]       fin_val;
	logic                w_act;
	logic [TW-1:0]       act_val;
	logic                do_frame;
	logic                do_clear;

	always_comb begin
		bval_s1 = int'(btn_s1) < NB;
		idx_s1  = btn_s1[IW-1:0];
		d_cur   = bval_s1 ? desired_q[idx_s1] : 1'b0;
		st_cur  = bval_s1 ? start_q[idx_s1] : '0;
		fin_cur = bval_s1 ? finish_q[idx_s1] : '0;
		act_cur = bval_s1 ? act_q[idx_s1] : '0;
		lock    = (fin_cur != '0) && ((now_s1 - fin_cur) < TW'(lockout_q));
		rel_fin = (act_cur >= st_cur) ? act_cur : now_s1;

		status_s1 = ST_APPLIED;
		d_new     = d_cur;
		w_start   = 1'b0;
		w_fin     = 1'b0;
		fin_val   = rel_fin;
		w_act     = 1'b0;
		act_val   = '0;
		do_frame  = 1'b0;
		do_clear  = 1'b0;

		unique case (op_s1)
			OP_SET: begin
				if (!bval_s1) begin
					status_s1 = ST_BAD;
				end else if (press_s1 == d_cur) begin
					status_s1 = ST_NOCHANGE;
				end else if (press_s1) begin
					if (lock) begin
						status_s1 = ST_LOCKOUT;
					end else begin
						d_new   = 1'b1;
						w_start = 1'b1;
						w_act   = 1'b1;
						act_val = now_s1;
					end
				end else begin
					d_new = 1'b0;
					w_fin = 1'b1;
					w_act = 1'b1;
				end
			end
			OP_CLICK: begin
				if (!bval_s1) begin
					status_s1 = ST_BAD;
				end else if (!d_cur && lock) begin
					status_s1 = ST_LOCKOUT;
				end else begin
					d_new   = 1'b0;
					w_start = !d_cur;
					w_fin   = 1'b1;
					fin_val = d_cur ? rel_fin : now_s1;
					w_act   = 1'b1;
				end
			end
			OP_ACTIVITY: begin
				if (!bval_s1) begin
					status_s1 = ST_BAD;
				end else begin
					w_act   = 1'b1;
					act_val = now_s1;
				end
			end
			OP_FRAME: do_frame = 1'b1;
			OP_CLEAR: do_clear = 1'b1;
			default:  status_s1 = ST_BAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lockout_q <= LOCKOUT_RESET;
		end else if (cfg_we) begin
			lockout_q <= cfg_wdata;
		end
	end

	// Apply the request to the button state as it leaves stage 1.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			desired_q  <= '0;
			latched_q  <= '0;
			prior_q    <= '0;
			last_usb_q <= 1'b0;
			usb_flag_q <= 1'b0;
			for (int i = 0; i < NB; i++) begin
				start_q[i]  <= '0;
				finish_q[i] <= '0;
				act_q[i]    <= '0;
			end
		end else if (v_s1 && s2_move) begin
			if (do_clear) begin
				desired_q <= '0;
				latched_q <= '0;
				prior_q   <= '0;
				for (int i = 0; i < NB; i++) begin
					start_q[i]  <= '0;
					finish_q[i] <= '0;
					act_q[i]    <= '0;
				end
			end else begin
				if (do_frame) begin
					prior_q    <= latched_q;
					latched_q  <= desired_q;
					usb_flag_q <= usb_s1 != last_usb_q;
					last_usb_q <= usb_s1;
				end
				for (int i = 0; i < NB; i++) begin
					if (bval_s1 && (IW'(i) == idx_s1)) begin
						desired_q[i] <= d_new;
						if (w_start) begin
							start_q[i] <= now_s1;
						end
						if (w_fin) begin
							finish_q[i] <= fin_val;
						end
						if (w_act) begin
							act_q[i] <= act_val;
						end
					end
				end
			end
		end
	end

	// Stage 2: held times from the updated state.
	logic [TW-1:0]   held [NB];
	logic [TW-1:0]   held_mx;
	logic [TW-1:0]   held_item;
	logic [NB-1:0]   rel_edges;
	vbrl_rsp_t       rsp_d;

	always_comb begin
		rel_edges = prior_q & ~latched_q;
		held_mx   = '0;
		for (int i = 0; i < NB; i++) begin
			if (latched_q[i]) begin
				held[i] = (act_q[i] >= start_q[i]) ? (act_q[i] - start_q[i])
				                                   : (now_s2 - start_q[i]);
			end else if (rel_edges[i]) begin
				held[i] = finish_q[i] - start_q[i];
			end else begin
				held[i] = '0;
			end
			if (held[i] > held_mx) begin
				held_mx = held[i];
			end
		end
		held_item = bval_s2 ? held[idx_s2] : '0;

		rsp_d.current_mask   = OUT_MASK_W'(latched_q);
		rsp_d.pressed_edges  = OUT_MASK_W'(latched_q & ~prior_q);
		rsp_d.released_edges = OUT_MASK_W'(rel_edges);
		rsp_d.held_ms        = FIELD_TW'(held_item);
		rsp_d.max_held_ms    = FIELD_TW'(held_mx);
		rsp_d.usb_changed    = usb_flag_q;
		rsp_d.status         = status_s2;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (s1_move) begin
				v_s1 <= req_valid;
			end
			if (s2_move) begin
				v_s2 <= v_s1;
			end
			if (out_free) begin
				rsp_valid_q <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move && req_valid) begin
			op_s1    <= req.operation;
			btn_s1   <= req.button;
			press_s1 <= req.press;
			now_s1   <= TW'(req.now_ms);
			usb_s1   <= req.usb_level;
		end
		if (s2_move && v_s1) begin
			bval_s2   <= bval_s1;
			idx_s2    <= idx_s1;
			now_s2    <= now_s1;
			status_s2 <= status_s1;
		end
		if (out_free && v_s2) begin
			rsp_q <= rsp_d;
		end
	end

	a_clear_zeroes_masks: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && s2_move && do_clear) |=> (desired_q == '0 && latched_q == '0 && prior_q == '0))
		else $error("clear request left a mask set");

	a_frame_shifts_masks: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && s2_move && do_frame) |=>
			(latched_q == $past(desired_q) && prior_q == $past(latched_q)))
		else $error("frame update did not shift masks");

	a_lockout_holds_desired: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && s2_move && status_s1 == ST_LOCKOUT) |=> (desired_q == $past(desired_q)))
		else $error("rejected press changed the desired mask");

	a_rsp_from_stage2: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(v_s2))
		else $error("response raised without a request in stage 2");

endmodule
